// ===== rtl/sbrp_pkg.sv =====
// Shared types and constants for the servo bus response parser.
// No dependencies; imported by sbrp_core, servo_bus_response_parser and the testbench.
`default_nettype none

package sbrp_pkg;

  localparam logic [7:0]  HdrByte      = 8'h55;
  localparam logic [7:0]  SumOk        = 8'hFF;
  localparam logic [7:0]  LenMin       = 8'd3;
  localparam logic [7:0]  LenMax       = 8'd7;
  localparam logic [2:0]  MaxPayload   = 3'd4;
  localparam logic [15:0] TimeoutReset = 16'd100;
  localparam logic [15:0] ElapsedMax   = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_ID_MISS    = 3'd2,
    ST_BAD_LEN    = 3'd3,
    ST_CMD_MISS   = 3'd4,
    ST_CHECKSUM   = 3'd5,
    ST_TIMEOUT    = 3'd6
  } status_e;

  // Frame walk: two header bytes, id, length, command, then payload/checksum
  typedef enum logic [2:0] {
    POS_HDR0 = 3'd0,
    POS_HDR1 = 3'd1,
    POS_ID   = 3'd2,
    POS_LEN  = 3'd3,
    POS_CMD  = 3'd4,
    POS_BODY = 3'd5
  } pos_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] expected_id;
    logic [7:0] expected_cmd;
    logic [2:0] capacity;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [1:0] data_index;
    logic [2:0] status;
    logic [2:0] frame_length;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/sbrp_core.sv =====
// Parser state and per-item step logic: header/id/length/command checks,
// payload emit, checksum and timeout. Depends on sbrp_pkg.
`default_nettype none

module sbrp_core import sbrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] timeout_ms_i,
  input  logic        step_i,
  input  item_t       item_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  logic        active_q, active_d;
  pos_e        pos_q, pos_d;
  logic [7:0]  want_id_q, want_id_d;
  logic [7:0]  want_cmd_q, want_cmd_d;
  logic [2:0]  length_q, length_d;
  logic [7:0]  sum_q, sum_d;
  logic [2:0]  count_q, count_d;
  logic [2:0]  limit_q, limit_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic        fin, emit;
  status_e     fin_status;
  logic [2:0]  fin_flen;
  logic [15:0] tick_inc;
  logic        timer_on;
  logic        in_body;
  logic [7:0]  sum_plus;
  logic [7:0]  rx;

  assign rx       = item_i.rx_byte;
  assign tick_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 16'd1;
  assign timer_on = (timeout_ms_i != 16'd0);
  assign in_body  = (count_q < (length_q - LenMin[2:0]));
  assign sum_plus = sum_q + rx;

  // Decide whether this item ends the response or emits a payload byte
  always_comb begin
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_flen   = 3'd0;
    emit       = 1'b0;
    if (step_i && active_q) begin
      if (item_i.action == ACT_TICK) begin
        if (timer_on && (tick_inc >= timeout_ms_i)) begin
          fin        = 1'b1;
          fin_status = ST_TIMEOUT;
          fin_flen   = length_q;
        end
      end else if (item_i.action == ACT_BYTE) begin
        unique case (pos_q)
          POS_HDR0, POS_HDR1: begin
            if (rx != HdrByte) begin
              fin        = 1'b1;
              fin_status = ST_BAD_HEADER;
            end
          end
          POS_ID: begin
            if (rx != want_id_q) begin
              fin        = 1'b1;
              fin_status = ST_ID_MISS;
            end
          end
          POS_LEN: begin
            if ((rx < LenMin) || (rx > LenMax)) begin
              fin        = 1'b1;
              fin_status = ST_BAD_LEN;
            end
          end
          POS_CMD: begin
            if (rx != want_cmd_q) begin
              fin        = 1'b1;
              fin_status = ST_CMD_MISS;
              fin_flen   = length_q;
            end
          end
          POS_BODY: begin
            if (in_body) begin
              emit = (count_q < limit_q);
            end else begin
              fin        = 1'b1;
              fin_status = (sum_plus == SumOk) ? ST_OK : ST_CHECKSUM;
              fin_flen   = length_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Next state
  always_comb begin
    active_d   = active_q;
    pos_d      = pos_q;
    want_id_d  = want_id_q;
    want_cmd_d = want_cmd_q;
    length_d   = length_q;
    sum_d      = sum_q;
    count_d    = count_q;
    limit_d    = limit_q;
    elapsed_d  = elapsed_q;
    if (step_i) begin
      if (item_i.action == ACT_START) begin
        // rearm; a response in flight is dropped silently
        active_d   = 1'b1;
        pos_d      = POS_HDR0;
        want_id_d  = item_i.expected_id;
        want_cmd_d = item_i.expected_cmd;
        length_d   = 3'd0;
        sum_d      = 8'd0;
        count_d    = 3'd0;
        limit_d    = (item_i.capacity > MaxPayload) ? MaxPayload : item_i.capacity;
        elapsed_d  = 16'd0;
      end else if (fin) begin
        active_d = 1'b0;
        pos_d    = POS_HDR0;
      end else if (active_q && (item_i.action == ACT_TICK)) begin
        if (timer_on) begin
          elapsed_d = tick_inc;
        end
      end else if (active_q && (item_i.action == ACT_BYTE)) begin
        unique case (pos_q)
          POS_HDR0: pos_d = POS_HDR1;
          POS_HDR1: pos_d = POS_ID;
          POS_ID: begin
            sum_d = rx;
            pos_d = POS_LEN;
          end
          POS_LEN: begin
            length_d = rx[2:0];
            sum_d    = sum_plus;
            pos_d    = POS_CMD;
          end
          POS_CMD: begin
            sum_d   = sum_plus;
            count_d = 3'd0;
            pos_d   = POS_BODY;
          end
          POS_BODY: begin
            sum_d   = sum_plus;
            count_d = count_q + 3'd1;
          end
          default: ;
        endcase
      end
    end
  end

  // Result fields
  always_comb begin
    res_valid_o = fin | emit;
    res_o       = '0;
    if (fin) begin
      res_o.result_kind  = 1'b1;
      res_o.status       = fin_status;
      res_o.frame_length = fin_flen;
      res_o.last         = 1'b1;
    end else if (emit) begin
      res_o.data_byte    = rx;
      res_o.data_index   = count_q[1:0];
      res_o.frame_length = length_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      pos_q      <= POS_HDR0;
      want_id_q  <= 8'd0;
      want_cmd_q <= 8'd0;
      length_q   <= 3'd0;
      sum_q      <= 8'd0;
      count_q    <= 3'd0;
      limit_q    <= 3'd0;
      elapsed_q  <= 16'd0;
    end else begin
      active_q   <= active_d;
      pos_q      <= pos_d;
      want_id_q  <= want_id_d;
      want_cmd_q <= want_cmd_d;
      length_q   <= length_d;
      sum_q      <= sum_d;
      count_q    <= count_d;
      limit_q    <= limit_d;
      elapsed_q  <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/servo_bus_response_parser.sv =====
// Top level of the servo bus response parser: input register, timeout
// register, result register around sbrp_core. Depends on sbrp_pkg, sbrp_core.
`default_nettype none

// Channel   Direction  Handshake               Contents
// in        input      in_valid_i/in_ready_o   action, rx_byte, expected_id,
//                                               expected_cmd, capacity
// out       output     out_valid_o/out_ready_i result_kind, data_byte,
//                                               data_index, status,
//                                               frame_length, last
// cfg       input      cfg_we_i                timeout_ms (cfg_wdata_i)
//
// One item per cycle sustained while the result register is free or draining;
// each item passes the input register, then the result register.
// The step logic in sbrp_core sets the cycle; it is a compare/add per byte.
// Reset clears the parser to idle and loads timeout_ms with 100.
// A stalled result holds the input register; one more item can still be
// taken into it, after which in_ready_o drops until the result leaves.

module servo_bus_response_parser import sbrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  expected_id_i,
  input  logic [7:0]  expected_cmd_i,
  input  logic [2:0]  capacity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  data_index_o,
  output logic [2:0]  status_o,
  output logic [2:0]  frame_length_o,
  output logic        last_o
);

  logic [15:0] timeout_q;
  logic        s1_valid_q;
  item_t       s1_item_q;
  logic        s1_adv;
  logic        in_xfer;
  logic        out_valid_q, out_valid_d;
  res_t        out_res_q;
  logic        core_valid;
  res_t        core_res;

  // Stage advance when the result register is free or draining
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= '{action:       action_i,
                     rx_byte:      rx_byte_i,
                     expected_id:  expected_id_i,
                     expected_cmd: expected_cmd_i,
                     capacity:     capacity_i};
    end
  end

  sbrp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .timeout_ms_i (timeout_q),
    .step_i       (s1_adv),
    .item_i       (s1_item_q),
    .res_valid_o  (core_valid),
    .res_o        (core_res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = core_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && core_valid) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_res_q.result_kind;
  assign data_byte_o    = out_res_q.data_byte;
  assign data_index_o   = out_res_q.data_index;
  assign status_o       = out_res_q.status;
  assign frame_length_o = out_res_q.frame_length;
  assign last_o         = out_res_q.last;

endmodule

`default_nettype wire

// ===== bench/servo_bus_response_parser_tb.sv =====
// Testbench for servo_bus_response_parser: random and directed response frames,
// checked against a cycle-free predictor held in a scoreboard class.
// Depends on sbrp_pkg and the servo_bus_response_parser RTL.
`timescale 1ns / 100ps

module servo_bus_response_parser_tb;
  import sbrp_pkg::*;

  localparam int DrainCycles = 6;
  localparam int CycleLimit  = 80000;
  localparam int RandomItems = 1850;
  localparam int ReportMax   = 10;
  localparam int PhaseCount  = 6;

  // Action code with no meaning; the parser must ignore it
  localparam logic [1:0] ActUnused = 2'd3;

  // Ways a generated frame can be damaged
  typedef enum int {
    FAULT_NONE,
    FAULT_HEADER,
    FAULT_ID,
    FAULT_LEN,
    FAULT_CMD,
    FAULT_SUM,
    FAULT_CUT
  } fault_e;

  // Predicts parser replies and compares them with what the block sends
  class reply_scoreboard;
    logic [15:0] timeout_ms;
    logic        busy;
    pos_e        pos;
    logic [7:0]  want_id;
    logic [7:0]  want_cmd;
    logic [2:0]  flen;
    logic [7:0]  sum;
    logic [2:0]  count;
    logic [2:0]  limit;
    logic [15:0] elapsed;
    res_t        expected_replies[$];
    int          errors;
    int          payloads;
    int          statuses[8];

    function new();
      timeout_ms = TimeoutReset;
      busy = 1'b0;
      pos = POS_HDR0;
      want_id = '0;
      want_cmd = '0;
      flen = '0;
      sum = '0;
      count = '0;
      limit = '0;
      elapsed = '0;
      errors = 0;
      payloads = 0;
      foreach (statuses[i]) statuses[i] = 0;
    endfunction

    function void load_timeout(input logic [15:0] v);
      timeout_ms = v;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Closing status of a response; returns the parser to idle
    function res_t end_reply(input status_e st, input logic [2:0] fl);
      res_t r;
      r = '0;
      r.result_kind = 1'b1;
      r.status = st;
      r.frame_length = fl;
      r.last = 1'b1;
      busy = 1'b0;
      pos = POS_HDR0;
      return r;
    endfunction

    // One transfer through the parser; returns 1 when it yields a reply
    function bit parse_step(input item_t it, output res_t r);
      logic [7:0] b;
      logic [2:0] idx;
      r = '0;
      b = it.rx_byte;
      if (it.action == ACT_START) begin
        busy = 1'b1;
        pos = POS_HDR0;
        want_id = it.expected_id;
        want_cmd = it.expected_cmd;
        flen = '0;
        sum = '0;
        count = '0;
        limit = (it.capacity > MaxPayload) ? MaxPayload : it.capacity;
        elapsed = '0;
        return 0;
      end
      if (!busy) return 0;
      if (it.action == ACT_TICK) begin
        if (timeout_ms == 16'd0) return 0;
        if (elapsed < ElapsedMax) elapsed++;
        if (elapsed >= timeout_ms) begin
          r = end_reply(ST_TIMEOUT, flen);
          return 1;
        end
        return 0;
      end
      if (it.action != ACT_BYTE) return 0;
      case (pos)
        POS_HDR0, POS_HDR1: begin
          if (b != HdrByte) begin
            r = end_reply(ST_BAD_HEADER, 3'd0);
            return 1;
          end
          pos = (pos == POS_HDR0) ? POS_HDR1 : POS_ID;
        end
        POS_ID: begin
          if (b != want_id) begin
            r = end_reply(ST_ID_MISS, 3'd0);
            return 1;
          end
          sum = b;
          pos = POS_LEN;
        end
        POS_LEN: begin
          // out-of-range length never reaches the 3-bit field
          if (b < LenMin || b > LenMax) begin
            r = end_reply(ST_BAD_LEN, 3'd0);
            return 1;
          end
          flen = b[2:0];
          sum = sum + b;
          pos = POS_CMD;
        end
        POS_CMD: begin
          if (b != want_cmd) begin
            r = end_reply(ST_CMD_MISS, flen);
            return 1;
          end
          sum = sum + b;
          count = '0;
          pos = POS_BODY;
        end
        default: begin
          if (count < flen - LenMin[2:0]) begin
            idx = count;
            sum = sum + b;
            count++;
            // bytes past the capacity are summed but not sent
            if (idx < limit) begin
              r.result_kind = 1'b0;
              r.data_byte = b;
              r.data_index = idx[1:0];
              r.frame_length = flen;
              return 1;
            end
            return 0;
          end
          if (8'(b + sum) == SumOk) r = end_reply(ST_OK, flen);
          else r = end_reply(ST_CHECKSUM, flen);
          return 1;
        end
      endcase
      return 0;
    endfunction

    function void note_transfer(input item_t it);
      res_t r;
      if (parse_step(it, r)) expected_replies.push_back(r);
    endfunction

    function void check_result(input res_t got);
      res_t want;
      if (got.result_kind) statuses[got.status]++;
      else payloads++;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= ReportMax)
          $display("unexpected reply: kind %0d byte %02h idx %0d status %0d len %0d last %0d",
                   got.result_kind, got.data_byte, got.data_index, got.status,
                   got.frame_length, got.last);
        return;
      end
      want = expected_replies.pop_front();
      if (got.result_kind !== want.result_kind || got.data_byte !== want.data_byte ||
          got.data_index !== want.data_index || got.status !== want.status ||
          got.frame_length !== want.frame_length || got.last !== want.last) begin
        errors++;
        if (errors <= ReportMax) begin
          $display("reply mismatch: expected kind %0d byte %02h idx %0d status %0d len %0d last %0d",
                   want.result_kind, want.data_byte, want.data_index, want.status,
                   want.frame_length, want.last);
          $display("  actual kind %0d byte %02h idx %0d status %0d len %0d last %0d",
                   got.result_kind, got.data_byte, got.data_index, got.status,
                   got.frame_length, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [7:0]  rx_byte_i;
  logic [7:0]  expected_id_i;
  logic [7:0]  expected_cmd_i;
  logic [2:0]  capacity_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        result_kind_o;
  logic [7:0]  data_byte_o;
  logic [1:0]  data_index_o;
  logic [2:0]  status_o;
  logic [2:0]  frame_length_o;
  logic        last_o;

  reply_scoreboard board;
  int  transfers;
  int  settings;
  int  cycle_count;
  int  tick_pct;
  bit  steady;

  servo_bus_response_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .rx_byte_i      (rx_byte_i),
    .expected_id_i  (expected_id_i),
    .expected_cmd_i (expected_cmd_i),
    .capacity_i     (capacity_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .data_byte_o    (data_byte_o),
    .data_index_o   (data_index_o),
    .status_o       (status_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  // Reply side: random stall before each transfer, then check it
  initial begin
    int   gap;
    res_t got;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.result_kind = result_kind_o;
      got.data_byte = data_byte_o;
      got.data_index = data_index_o;
      got.status = status_o;
      got.frame_length = frame_length_o;
      got.last = last_o;
      board.check_result(got);
    end
  end

  // Byte value biased toward the interesting ones
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return HdrByte;
      default: return 8'($urandom);
    endcase
  endfunction

  // Item of one action with every unused field random
  function automatic item_t rand_item(input logic [1:0] act);
    item_t it;
    it.action = act;
    it.rx_byte = 8'($urandom);
    it.expected_id = 8'($urandom);
    it.expected_cmd = 8'($urandom);
    it.capacity = 3'($urandom);
    return it;
  endfunction

  // Offer one item after a random gap; returns at its transfer edge
  task automatic send_item(input item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= it.action;
    rx_byte_i <= it.rx_byte;
    expected_id_i <= it.expected_id;
    expected_cmd_i <= it.expected_cmd;
    capacity_i <= it.capacity;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    board.note_transfer(it);
    transfers++;
  endtask

  task automatic send_start(input logic [7:0] id, input logic [7:0] cmd,
                            input logic [2:0] cap);
    item_t it;
    it = rand_item(ACT_START);
    it.expected_id = id;
    it.expected_cmd = cmd;
    it.capacity = cap;
    send_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    item_t it;
    it = rand_item(ACT_BYTE);
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(rand_item(ACT_TICK));
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_item(rand_item(2'($urandom_range(0, 3))));
  endtask

  // Hold off the sender until every reply is in and the pipe is empty
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    drain_replies();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.load_timeout(v);
    settings++;
  endtask

  // Start plus a full response frame, optionally damaged, with ticks mixed in
  task automatic send_frame(input logic [7:0] id, input logic [7:0] cmd,
                            input logic [2:0] cap, input int len, input fault_e fault);
    logic [7:0] fb[12];
    logic [7:0] sum;
    logic [7:0] flip;
    int         n;
    int         k;
    flip = 8'($urandom_range(1, 255));
    fb[0] = HdrByte;
    fb[1] = HdrByte;
    fb[2] = id;
    fb[3] = 8'(len);
    fb[4] = cmd;
    sum = id + 8'(len) + cmd;
    for (k = 0; k < len - 3; k++) begin
      fb[5 + k] = pick_byte();
      sum = sum + fb[5 + k];
    end
    fb[len + 2] = ~sum;
    n = len + 3;
    case (fault)
      FAULT_HEADER: fb[$urandom_range(0, 1)] = HdrByte ^ flip;
      FAULT_ID:     fb[2] = id ^ flip;
      FAULT_LEN:    fb[3] = $urandom_range(0, 1) ? 8'($urandom_range(0, 2))
                                                 : 8'($urandom_range(8, 255));
      FAULT_CMD:    fb[4] = cmd ^ flip;
      FAULT_SUM:    fb[len + 2] = fb[len + 2] ^ flip;
      FAULT_CUT:    n = $urandom_range(1, n - 1);
      default: ;
    endcase
    send_start(id, cmd, cap);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < tick_pct) send_ticks($urandom_range(1, 3));
      send_byte(fb[k]);
    end
  endtask

  // Main sequence
  initial begin
    logic [15:0] phase_timeout[PhaseCount];
    int          phase_ticks[PhaseCount];
    int          phase_base;
    int          r;
    logic [7:0]  id;
    board = new();
    transfers = 0;
    settings = 0;
    tick_pct = 0;
    steady = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    action_i = ACT_TICK;
    rx_byte_i = '0;
    expected_id_i = '0;
    expected_cmd_i = '0;
    capacity_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle noise, capacity above four, restart while busy,
    // shortest frame, bad length byte; timeout at its reset value
    send_ticks(1);
    send_byte(8'hFF);
    send_item(rand_item(ActUnused));
    send_frame(8'hFF, 8'h00, 3'd7, 7, FAULT_NONE);
    send_start(8'h12, 8'h34, 3'd2);
    send_frame(8'h00, 8'hFF, 3'd0, 3, FAULT_NONE);
    send_start(8'h01, 8'h02, 3'd4);
    send_byte(HdrByte);
    send_byte(HdrByte);
    send_byte(8'h01);
    send_byte(8'h00);

    // Timeout lowered while a response is open
    write_timeout(16'd2);
    send_start(8'h21, 8'h07, 3'd1);
    send_ticks(1);
    write_timeout(16'd1);
    send_ticks(1);

    // Timeout of zero never expires
    write_timeout(16'd0);
    tick_pct = 50;
    send_frame(8'h42, 8'h1C, 3'd3, 5, FAULT_NONE);
    send_ticks(4);
    tick_pct = 0;

    // Longest timeout, a burst of ticks without idling stays short of it
    write_timeout(16'hFFFF);
    steady = 1'b1;
    send_start(8'h05, 8'h0A, 3'd4);
    send_ticks(40);
    steady = 1'b0;

    // Random phases over several timeout settings
    phase_timeout[0] = 16'd7;
    phase_timeout[1] = 16'd0;
    phase_timeout[2] = 16'd1;
    phase_timeout[3] = 16'hFFFF;
    phase_timeout[4] = 16'($urandom_range(2, 40));
    phase_timeout[5] = TimeoutReset;
    phase_ticks[0] = 15;
    phase_ticks[1] = 30;
    phase_ticks[2] = 5;
    phase_ticks[3] = 10;
    phase_ticks[4] = 25;
    phase_ticks[5] = 20;
    for (int p = 0; p < PhaseCount; p++) begin
      write_timeout(phase_timeout[p]);
      tick_pct = phase_ticks[p];
      phase_base = transfers;
      while (transfers - phase_base < RandomItems / PhaseCount) begin
        if ($urandom_range(0, 19) == 0) steady = ~steady;
        r = $urandom_range(0, 99);
        id = pick_byte();
        if (r < 60)
          send_frame(id, pick_byte(), 3'($urandom), $urandom_range(3, 7), FAULT_NONE);
        else if (r < 88)
          send_frame(id, pick_byte(), 3'($urandom), $urandom_range(3, 7),
                     fault_e'($urandom_range(FAULT_HEADER, FAULT_CUT)));
        else
          send_noise($urandom_range(1, 4));
      end
    end
    steady = 1'b0;

    // Wrap up once every reply has arrived
    drain_replies();
    $display("Covered %0d transfers over %0d timeout settings: %0d payload bytes checked",
             transfers, settings, board.payloads);
    $display("Status counts ok/hdr/id/len/cmd/sum/timeout: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             board.statuses[ST_OK], board.statuses[ST_BAD_HEADER], board.statuses[ST_ID_MISS],
             board.statuses[ST_BAD_LEN], board.statuses[ST_CMD_MISS],
             board.statuses[ST_CHECKSUM], board.statuses[ST_TIMEOUT]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d replies missing", board.errors, board.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
